### hw/rtl/pam_pkg.sv
// pam_pkg: shared constants, action codes and control structs for the
// polynomial add/multiply unit; no dependencies
`default_nettype none

package pam_pkg;

    // default operand capacity
    localparam int MAX_TERMS_DEF = 16;

    // fixed field widths
    localparam int ACTION_W = 3;
    localparam int COEF_W   = 16;
    localparam int VALUE_W  = 48;
    localparam int POWER_W  = 5;
    localparam int PROD_W   = 2 * COEF_W;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_LOAD_A = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_B = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SUM    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_PROD   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

    // output register source select
    typedef logic [1:0] t_out_sel;
    localparam t_out_sel OUT_SUM  = 2'd0;
    localparam t_out_sel OUT_ACC  = 2'd1;
    localparam t_out_sel OUT_ZERO = 2'd2;
    localparam t_out_sel OUT_ERR  = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic     wr_a;
        logic     wr_b;
        logic     clr_counts;
        logic     k_clear;
        logic     k_inc;
        logic     i_init;
        logic     i_inc;
        logic     rd_sum;
        logic     mac_issue;
        logic     acc_clear;
        logic     out_load;
        t_out_sel out_sel;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic full_a;
        logic full_b;
        logic empty_any;
        logic i_at_hi;
        logic k_last_sum;
        logic k_last_prod;
        logic pipe_busy;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

### hw/rtl/pam_ram.sv
// pam_ram: generic single write, single read RAM with registered read data
// no dependencies
`default_nettype none

module pam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, data holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### hw/rtl/pam_ctrl.sv
// pam_ctrl: sequencer for loads, sum runs and product runs
// depends on pam_pkg
`default_nettype none

module pam_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [pam_pkg::ACTION_W-1:0] i_action,
    input  wire pam_pkg::t_dp_stat            i_stat,
    output pam_pkg::t_dp_cmd                  o_cmd
);

    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_ERR        = 3'd1;
    localparam logic [2:0] ST_ZERO       = 3'd2;
    localparam logic [2:0] ST_SUM_RD     = 3'd3;
    localparam logic [2:0] ST_SUM_OUT    = 3'd4;
    localparam logic [2:0] ST_PROD_START = 3'd5;
    localparam logic [2:0] ST_PROD_MAC   = 3'd6;
    localparam logic [2:0] ST_PROD_DRAIN = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // one item at a time, taken only when idle
    assign o_in_ready = (r_state == ST_IDLE);

    // next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_action)
                        pam_pkg::ACT_LOAD_A: begin
                            if (i_stat.full_a) begin
                                n_state = ST_ERR;
                            end else begin
                                o_cmd.wr_a = 1'b1;
                            end
                        end
                        pam_pkg::ACT_LOAD_B: begin
                            if (i_stat.full_b) begin
                                n_state = ST_ERR;
                            end else begin
                                o_cmd.wr_b = 1'b1;
                            end
                        end
                        pam_pkg::ACT_SUM: begin
                            if (i_stat.empty_any) begin
                                n_state = ST_ZERO;
                            end else begin
                                o_cmd.k_clear = 1'b1;
                                n_state       = ST_SUM_RD;
                            end
                        end
                        pam_pkg::ACT_PROD: begin
                            if (i_stat.empty_any) begin
                                n_state = ST_ZERO;
                            end else begin
                                o_cmd.k_clear = 1'b1;
                                n_state       = ST_PROD_START;
                            end
                        end
                        pam_pkg::ACT_CLEAR: begin
                            o_cmd.clr_counts = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ERR: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = pam_pkg::OUT_ERR;
                    n_state        = ST_IDLE;
                end
            end
            ST_ZERO: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = pam_pkg::OUT_ZERO;
                    n_state        = ST_IDLE;
                end
            end
            ST_SUM_RD: begin
                o_cmd.rd_sum = 1'b1;
                n_state      = ST_SUM_OUT;
            end
            ST_SUM_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = pam_pkg::OUT_SUM;
                    if (i_stat.k_last_sum) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.k_inc = 1'b1;
                        n_state     = ST_SUM_RD;
                    end
                end
            end
            ST_PROD_START: begin
                o_cmd.i_init    = 1'b1;
                o_cmd.acc_clear = 1'b1;
                n_state         = ST_PROD_MAC;
            end
            ST_PROD_MAC: begin
                o_cmd.mac_issue = 1'b1;
                o_cmd.i_inc     = 1'b1;
                if (i_stat.i_at_hi) begin
                    n_state = ST_PROD_DRAIN;
                end
            end
            ST_PROD_DRAIN: begin
                if (!i_stat.pipe_busy && i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = pam_pkg::OUT_ACC;
                    if (i_stat.k_last_prod) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.k_inc = 1'b1;
                        n_state     = ST_PROD_START;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pam_datapath.sv
// pam_datapath: operand stores, counts, term indexes, multiply-accumulate
// pipeline and output register; depends on pam_pkg and pam_ram
`default_nettype none

module pam_datapath #(
    parameter int MAX_TERMS = pam_pkg::MAX_TERMS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire pam_pkg::t_dp_cmd                   i_cmd,
    output pam_pkg::t_dp_stat                       o_stat,
    input  wire logic signed [pam_pkg::COEF_W-1:0]  i_coefficient,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic             [pam_pkg::POWER_W-1:0] o_power,
    output logic signed      [pam_pkg::VALUE_W-1:0] o_term_value,
    output logic                                    o_last_term,
    output logic                                    o_load_error
);

    localparam int IW  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CW  = $clog2(MAX_TERMS + 1);
    localparam int KW  = $clog2(2 * MAX_TERMS - 1);
    localparam int KW1 = KW + 1;
    localparam int CWD = pam_pkg::COEF_W;
    localparam int VW  = pam_pkg::VALUE_W;
    localparam int PW  = pam_pkg::PROD_W;
    localparam int PWD = pam_pkg::POWER_W;

    logic [CW-1:0] r_count_a;
    logic [CW-1:0] r_count_b;
    logic [KW-1:0] r_k;
    logic [IW-1:0] r_i;

    logic [KW-1:0]  w_ca_k;
    logic [KW-1:0]  w_cb_k;
    logic [CW-1:0]  w_ca_m1;
    logic [KW-1:0]  w_lo_full;
    logic [IW-1:0]  w_i_lo;
    logic [IW-1:0]  w_i_hi;
    logic [KW-1:0]  w_kmi;
    logic [CW-1:0]  w_n_sum;
    logic [KW1-1:0] w_k_p1;
    logic [KW1-1:0] w_k_p2;
    logic [KW1-1:0] w_n_prod2;

    logic [IW-1:0]  w_a_rd_addr;
    logic [IW-1:0]  w_b_rd_addr;
    logic           w_rd_en;
    logic [CWD-1:0] w_a_data;
    logic [CWD-1:0] w_b_data;

    logic                 r_v1;
    logic                 r_v2;
    logic signed [PW-1:0] r_prod;
    logic signed [VW-1:0] r_acc;
    logic signed [VW-1:0] w_sum_a;
    logic signed [VW-1:0] w_sum_b;
    logic signed [VW-1:0] w_sum_val;

    logic                 r_out_valid;
    logic [pam_pkg::POWER_W-1:0] r_power;
    logic signed [VW-1:0] r_value;
    logic                 r_last;
    logic                 r_err;
    logic                 w_out_free;

    // index window for one product term
    assign w_ca_k    = KW'(r_count_a);
    assign w_cb_k    = KW'(r_count_b);
    assign w_ca_m1   = r_count_a - CW'(1);
    assign w_lo_full = r_k - w_cb_k + KW'(1);
    assign w_i_lo    = (r_k >= w_cb_k) ? w_lo_full[IW-1:0] : '0;
    assign w_i_hi    = (r_k >= w_ca_k) ? w_ca_m1[IW-1:0] : r_k[IW-1:0];
    assign w_kmi     = r_k - KW'(r_i);

    // run length checks
    assign w_n_sum   = (r_count_a > r_count_b) ? r_count_a : r_count_b;
    assign w_k_p1    = KW1'(r_k) + KW1'(1);
    assign w_k_p2    = KW1'(r_k) + KW1'(2);
    assign w_n_prod2 = KW1'(r_count_a) + KW1'(r_count_b);

    // operand counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_a <= '0;
            r_count_b <= '0;
        end else if (i_cmd.clr_counts) begin
            r_count_a <= '0;
            r_count_b <= '0;
        end else begin
            if (i_cmd.wr_a) begin
                r_count_a <= r_count_a + CW'(1);
            end
            if (i_cmd.wr_b) begin
                r_count_b <= r_count_b + CW'(1);
            end
        end
    end

    // term and inner indexes
    always_ff @(posedge i_clk) begin
        if (i_cmd.k_clear) begin
            r_k <= '0;
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + KW'(1);
        end
        if (i_cmd.i_init) begin
            r_i <= w_i_lo;
        end else if (i_cmd.i_inc) begin
            r_i <= r_i + IW'(1);
        end
    end

    // operand stores
    assign w_rd_en     = i_cmd.rd_sum | i_cmd.mac_issue;
    assign w_a_rd_addr = i_cmd.rd_sum ? r_k[IW-1:0] : r_i;
    assign w_b_rd_addr = i_cmd.rd_sum ? r_k[IW-1:0] : w_kmi[IW-1:0];

    pam_ram #(
        .WIDTH (CWD),
        .DEPTH (MAX_TERMS)
    ) u_ram_a (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_a),
        .i_wr_addr (r_count_a[IW-1:0]),
        .i_wr_data (i_coefficient),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_a_rd_addr),
        .o_rd_data (w_a_data)
    );

    pam_ram #(
        .WIDTH (CWD),
        .DEPTH (MAX_TERMS)
    ) u_ram_b (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_b),
        .i_wr_addr (r_count_b[IW-1:0]),
        .i_wr_data (i_coefficient),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_b_rd_addr),
        .o_rd_data (w_b_data)
    );

    // multiply-accumulate pipeline: read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.mac_issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod <= $signed(w_a_data) * $signed(w_b_data);
        end
        if (i_cmd.acc_clear) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + VW'(r_prod);
        end
    end

    // term-wise sum, shorter operand padded with zero
    assign w_sum_a   = (r_k < w_ca_k) ? VW'($signed(w_a_data)) : '0;
    assign w_sum_b   = (r_k < w_cb_k) ? VW'($signed(w_b_data)) : '0;
    assign w_sum_val = w_sum_a + w_sum_b;

    // output register
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            case (i_cmd.out_sel)
                pam_pkg::OUT_SUM: begin
                    r_power <= PWD'(r_k);
                    r_value <= w_sum_val;
                    r_last  <= (w_k_p1 == KW1'(w_n_sum));
                    r_err   <= 1'b0;
                end
                pam_pkg::OUT_ACC: begin
                    r_power <= PWD'(r_k);
                    r_value <= r_acc;
                    r_last  <= (w_k_p2 == w_n_prod2);
                    r_err   <= 1'b0;
                end
                pam_pkg::OUT_ERR: begin
                    r_power <= '0;
                    r_value <= '0;
                    r_last  <= 1'b1;
                    r_err   <= 1'b1;
                end
                default: begin
                    r_power <= '0;
                    r_value <= '0;
                    r_last  <= 1'b1;
                    r_err   <= 1'b0;
                end
            endcase
        end
    end

    // status to controller
    always_comb begin
        o_stat             = '0;
        o_stat.full_a      = (r_count_a == CW'(MAX_TERMS));
        o_stat.full_b      = (r_count_b == CW'(MAX_TERMS));
        o_stat.empty_any   = (r_count_a == '0) || (r_count_b == '0);
        o_stat.i_at_hi     = (r_i == w_i_hi);
        o_stat.k_last_sum  = (w_k_p1 == KW1'(w_n_sum));
        o_stat.k_last_prod = (w_k_p2 == w_n_prod2);
        o_stat.pipe_busy   = r_v1 || r_v2;
        o_stat.out_free    = w_out_free;
    end

    assign o_out_valid  = r_out_valid;
    assign o_power      = r_power;
    assign o_term_value = r_value;
    assign o_last_term  = r_last;
    assign o_load_error = r_err;

endmodule

`default_nettype wire

### hw/rtl/polynomial_add_multiply_unit.sv
// channel    | direction | handshake                  | payload
// in         | input     | i_in_valid / o_in_ready    | i_action, i_coefficient
// out        | output    | o_out_valid / i_out_ready  | o_power, o_term_value,
//            |           |                            | o_last_term, o_load_error
//
// an item is taken only while the sequencer is idle
// a sum run reads each term, then loads it into the output register; a product run
// feeds each term's products to the single multiply-accumulate unit, then outputs the sum
// reset (i_rst_n, synchronous) empties both operands and the output register
// a stalled output beat holds the sequencer; the next item waits for the run to finish
//
// polynomial_add_multiply_unit: top level, joins controller and datapath
// depends on pam_pkg, pam_ctrl, pam_datapath
`default_nettype none

module polynomial_add_multiply_unit #(
    parameter int MAX_TERMS = pam_pkg::MAX_TERMS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic        [pam_pkg::ACTION_W-1:0] i_action,
    input  wire logic signed [pam_pkg::COEF_W-1:0]   i_coefficient,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic             [pam_pkg::POWER_W-1:0]  o_power,
    output logic signed      [pam_pkg::VALUE_W-1:0]  o_term_value,
    output logic                                     o_last_term,
    output logic                                     o_load_error
);

    pam_pkg::t_dp_cmd  w_cmd;
    pam_pkg::t_dp_stat w_stat;

    // sequencer
    pam_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_action   (i_action),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // storage and arithmetic
    pam_datapath #(
        .MAX_TERMS (MAX_TERMS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_coefficient (i_coefficient),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_power       (o_power),
        .o_term_value  (o_term_value),
        .o_last_term   (o_last_term),
        .o_load_error  (o_load_error)
    );

endmodule

`default_nettype wire

### hw/rtl/pam_checker.sv
// pam_checker: port-level checks for the polynomial add/multiply unit
// depends on pam_pkg; bound to polynomial_add_multiply_unit below
`default_nettype none

module pam_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_in_valid,
    input wire logic                                o_in_ready,
    input wire logic        [pam_pkg::ACTION_W-1:0] i_action,
    input wire logic signed [pam_pkg::COEF_W-1:0]   i_coefficient,
    input wire logic                                o_out_valid,
    input wire logic                                i_out_ready,
    input wire logic        [pam_pkg::POWER_W-1:0]  o_power,
    input wire logic signed [pam_pkg::VALUE_W-1:0]  o_term_value,
    input wire logic                                o_last_term,
    input wire logic                                o_load_error
);

    // a stalled beat stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("output beat dropped while stalled");

    // a stalled beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> ($stable(o_power) && $stable(o_term_value)
            && $stable(o_last_term) && $stable(o_load_error)))
        else $error("output payload changed while stalled");

    // an error beat is a lone zero term
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_load_error) |-> (o_last_term && (o_term_value == '0)
            && (o_power == '0)))
        else $error("load error beat is not a single zero term");

    // no new item while a run still has terms to send
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_term) |-> !o_in_ready)
        else $error("input ready in the middle of a run");

    // a waiting input beat keeps its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |=> (i_in_valid && $stable(i_action)
            && $stable(i_coefficient)))
        else $error("input beat changed while waiting");

endmodule

bind polynomial_add_multiply_unit pam_checker u_pam_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_action      (i_action),
    .i_coefficient (i_coefficient),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_power       (o_power),
    .o_term_value  (o_term_value),
    .o_last_term   (o_last_term),
    .o_load_error  (o_load_error)
);

`default_nettype wire
